@@ src/smpq_pkg.sv @@
package smpq_pkg;

	// Action codes of an input item
	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	// Status codes of a result
	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_PUSH_FULL  = 2'd1;
	localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} smpq_cmd_t;

endpackage

@@ src/stable_max_priority_queue.sv @@
// Stable max-first priority queue. Entries are held sorted in a chain of DEPTH cells, the
// highest priority at the head; equal priorities leave in arrival order. Every cell compares
// its key with the incoming one in parallel and moves toward its neighbor in the same cycle,
// so an item is taken on every clock: busy stays low and the result of an item accepted at
// one edge is shown with done high for the next cycle, one item per cycle.
// The receiver cannot stall; each result is there for exactly one cycle.
module stable_max_priority_queue
	import smpq_pkg::*;
#(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 32,
	localparam int CNT_BITS     = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               action,
	input  logic [PRIORITY_BITS-1:0] entry_priority,
	input  logic [PAYLOAD_BITS-1:0]  entry_data,
	output logic                     done,
	output logic                     head_valid,
	output logic [PRIORITY_BITS-1:0] head_priority,
	output logic [PAYLOAD_BITS-1:0]  head_data,
	output logic [CNT_BITS-1:0]      occupancy,
	output logic [1:0]               status
);

	logic [DEPTH-1:0]         ins_v;
	logic [DEPTH-1:0]         occ_v;
	logic [PRIORITY_BITS-1:0] prio_v [DEPTH];
	logic [PAYLOAD_BITS-1:0]  data_v [DEPTH];
	logic                     full;
	logic                     empty;
	smpq_cmd_t                cmd;
	logic [1:0]               status_d;
	logic [CNT_BITS-1:0]      cnt_q;
	logic [1:0]               status_q;
	logic                     done_q;

	assign busy  = 1'b0;
	assign full  = occ_v[DEPTH-1];
	assign empty = !occ_v[0];

	// Decode the item into a chain command; drop a push when full and a pop when empty
	always_comb begin
		cmd      = '0;
		status_d = ST_DONE;
		if (start) begin
			unique case (action)
				ACT_PUSH: begin
					if (full) status_d = ST_PUSH_FULL;
					else      cmd.push = 1'b1;
				end
				ACT_POP: begin
					if (empty) status_d = ST_POP_EMPTY;
					else       cmd.pop = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Build the chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     p_ins;
		logic [PRIORITY_BITS-1:0] p_prio;
		logic [PAYLOAD_BITS-1:0]  p_data;
		logic                     p_occ;
		logic [PRIORITY_BITS-1:0] n_prio;
		logic [PAYLOAD_BITS-1:0]  n_data;
		logic                     n_occ;

		if (i == 0) begin : g_head
			assign p_ins  = 1'b0;
			assign p_prio = '0;
			assign p_data = '0;
			assign p_occ  = 1'b0;
		end else begin : g_mid
			assign p_ins  = ins_v[i-1];
			assign p_prio = prio_v[i-1];
			assign p_data = data_v[i-1];
			assign p_occ  = occ_v[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_prio = '0;
			assign n_data = '0;
			assign n_occ  = 1'b0;
		end else begin : g_body
			assign n_prio = prio_v[i+1];
			assign n_data = data_v[i+1];
			assign n_occ  = occ_v[i+1];
		end

		smpq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.new_prio (entry_priority),
			.new_data (entry_data),
			.prev_ins (p_ins),
			.prev_prio(p_prio),
			.prev_data(p_data),
			.prev_occ (p_occ),
			.next_prio(n_prio),
			.next_data(n_data),
			.next_occ (n_occ),
			.ins      (ins_v[i]),
			.prio     (prio_v[i]),
			.data     (data_v[i]),
			.occ      (occ_v[i])
		);
	end

	// Track the fill count and register the strobe and status of each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			status_q <= ST_DONE;
			done_q   <= 1'b0;
		end else begin
			done_q <= start;
			if (start) status_q <= status_d;
			if (cmd.push)     cnt_q <= cnt_q + CNT_BITS'(1);
			else if (cmd.pop) cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	// Show the head; an empty slot reads as zero
	assign done          = done_q;
	assign head_valid    = occ_v[0];
	assign head_priority = prio_v[0];
	assign head_data     = occ_v[0] ? data_v[0] : '0;
	assign occupancy     = cnt_q;
	assign status        = status_q;

	// Occupied slots form a prefix whose length is the fill count
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(occ_v) == int'(cnt_q)) && ((occ_v & (occ_v + DEPTH'(1))) == '0))
		else $error("occupied slots do not match fill count");

	// A dropped push leaves the fill count as it was
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && action == ACT_PUSH && full) |=> (status == ST_PUSH_FULL && $stable(cnt_q)))
		else $error("push on full queue changed the state");

	// A pop taken from a nonempty queue lowers the fill count by one
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && action == ACT_POP && !empty) |=> (int'(cnt_q) == int'($past(cnt_q)) - 1))
		else $error("pop did not remove one entry");

	// The head key is never below the key of its successor
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		occ_v[1] |-> (prio_v[0] >= prio_v[1]))
		else $error("head key below its successor");

endmodule

@@ src/smpq_cell.sv @@
module smpq_cell
	import smpq_pkg::*;
#(
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  smpq_cmd_t                cmd,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic [PAYLOAD_BITS-1:0]  new_data,
	// neighbor toward the head
	input  logic                     prev_ins,
	input  logic [PRIORITY_BITS-1:0] prev_prio,
	input  logic [PAYLOAD_BITS-1:0]  prev_data,
	input  logic                     prev_occ,
	// neighbor toward the tail
	input  logic [PRIORITY_BITS-1:0] next_prio,
	input  logic [PAYLOAD_BITS-1:0]  next_data,
	input  logic                     next_occ,
	// own contents
	output logic                     ins,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic [PAYLOAD_BITS-1:0]  data,
	output logic                     occ
);

	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]  data_q;
	logic                     occ_q;
	logic                     take_prev;
	logic                     take_new;

	// A new entry lands at or before this slot when the slot is empty or holds a lower key;
	// equal keys keep the new entry behind them
	assign ins       = !occ_q || (prio_q < new_prio);
	assign take_prev = cmd.push && prev_ins;
	assign take_new  = cmd.push && !prev_ins && ins;

	// Priority and occupancy: shift down on insert ahead, load on insert here, shift up on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= '0;
			occ_q  <= 1'b0;
		end else if (take_prev) begin
			prio_q <= prev_prio;
			occ_q  <= prev_occ;
		end else if (take_new) begin
			prio_q <= new_prio;
			occ_q  <= 1'b1;
		end else if (cmd.pop) begin
			prio_q <= next_prio;
			occ_q  <= next_occ;
		end
	end

	// Payload follows the same moves, no reset
	always_ff @(posedge clk) begin
		if (take_prev) begin
			data_q <= prev_data;
		end else if (take_new) begin
			data_q <= new_data;
		end else if (cmd.pop) begin
			data_q <= next_data;
		end
	end

	assign prio = prio_q;
	assign data = data_q;
	assign occ  = occ_q;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import smpq_pkg::*;

	localparam int QDEPTH = 16;
	// Unnamed action code; behaves as peek
	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic        hv;
		logic [15:0] hp;
		logic [31:0] hd;
		logic [4:0]  occ;
		logic [1:0]  st;
	} head_report_t;

	typedef struct packed {
		logic [1:0]   act;
		logic [15:0]  prio;
		logic [31:0]  data;
		logic         typed;
		head_report_t want;
	} stim_row_t;

	typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} stretch_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  action = ACT_PEEK;
	logic [15:0] entry_priority = '0;
	logic [31:0] entry_data = '0;
	logic        busy;
	logic        done;
	logic        head_valid;
	logic [15:0] head_priority;
	logic [31:0] head_data;
	logic [4:0]  occupancy;
	logic [1:0]  status;

	// Shadow copy of the sorted chain
	logic [15:0] shadow_prio [QDEPTH];
	logic [31:0] shadow_data [QDEPTH];
	int          shadow_count = 0;

	head_report_t pending_heads[$];
	stim_row_t    stim_table[$];

	int errors = 0;
	int results_seen = 0;
	int n_push = 0, n_pop = 0, n_full = 0, n_empty = 0, n_peek = 0, peak_occ = 0;

	stable_max_priority_queue uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.entry_priority(entry_priority),
		.entry_data    (entry_data),
		.done          (done),
		.head_valid    (head_valid),
		.head_priority (head_priority),
		.head_data     (head_data),
		.occupancy     (occupancy),
		.status        (status)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Run the shadow queue one item forward and return the head it shows
	task automatic queue_step(input logic [1:0] a, input logic [15:0] p,
		input logic [31:0] d, output head_report_t r);
		int pos;
		int i;
		r.st = ST_DONE;
		if (a == ACT_PUSH) begin
			n_push++;
			if (shadow_count >= QDEPTH) begin
				r.st = ST_PUSH_FULL;
				n_full++;
			end else begin
				// new entry goes after every held entry of equal key
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] >= p)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_data[i] = shadow_data[i-1];
				end
				shadow_prio[pos] = p;
				shadow_data[pos] = d;
				shadow_count++;
			end
		end else if (a == ACT_POP) begin
			n_pop++;
			if (shadow_count == 0) begin
				r.st = ST_POP_EMPTY;
				n_empty++;
			end else begin
				for (i = 0; i + 1 < shadow_count; i++) begin
					shadow_prio[i] = shadow_prio[i+1];
					shadow_data[i] = shadow_data[i+1];
				end
				shadow_count--;
			end
		end else begin
			n_peek++;
		end
		if (shadow_count > peak_occ)
			peak_occ = shadow_count;
		r.hv  = (shadow_count != 0);
		r.hp  = (shadow_count != 0) ? shadow_prio[0] : 16'h0;
		r.hd  = (shadow_count != 0) ? shadow_data[0] : 32'h0;
		r.occ = shadow_count[4:0];
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		if (errors <= 40)
			$display("MISMATCH at result %0d, %s: got %h, expected %h",
				results_seen, what, got, want);
	endtask

	// Hold start until the item transfers
	task automatic send_item(input logic [1:0] a, input logic [15:0] p,
		input logic [31:0] d);
		start <= 1'b1;
		action <= a;
		entry_priority <= p;
		entry_data <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start for a while, with junk on the payload
	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			action <= 2'($urandom);
			entry_priority <= 16'($urandom);
			entry_data <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	// Predict after a transfer; a typed row overrides the shadow's answer
	task automatic issue(input stim_row_t row);
		head_report_t r;
		send_item(row.act, row.prio, row.data);
		queue_step(row.act, row.prio, row.data, r);
		pending_heads.push_back(row.typed ? row.want : r);
	endtask

	task automatic add_row(input logic [1:0] a, input logic [15:0] p, input logic [31:0] d);
		stim_row_t row;
		row = '0;
		row.act = a;
		row.prio = p;
		row.data = d;
		stim_table.push_back(row);
	endtask

	task automatic add_typed(input logic [1:0] a, input logic [15:0] p, input logic [31:0] d,
		input logic hv, input logic [15:0] hp, input logic [31:0] hd,
		input logic [4:0] occ, input logic [1:0] st);
		stim_row_t row;
		row.act = a;
		row.prio = p;
		row.data = d;
		row.typed = 1'b1;
		row.want.hv = hv;
		row.want.hp = hp;
		row.want.hd = hd;
		row.want.occ = occ;
		row.want.st = st;
		stim_table.push_back(row);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Bias keys toward ties and extremes
	function automatic logic [15:0] pick_priority();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 3));
			4: return 16'hFFFC + 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [1:0] pick_action(input stretch_mode_e m);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return ACT_PEEK;
		if (r < 7)
			return ACT_SPARE;
		case (m)
			MODE_FILL: return (r < 80) ? ACT_PUSH : ACT_POP;
			MODE_DRAIN: return (r < 27) ? ACT_PUSH : ACT_POP;
			default: return (r < 53) ? ACT_PUSH : ACT_POP;
		endcase
	endfunction

	// Compare each strobed result with the oldest prediction
	always @(posedge clk) begin : check_results
		head_report_t w;
		if (done) begin
			results_seen++;
			if (pending_heads.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(status), 32'h0);
			end else begin
				w = pending_heads.pop_front();
				if (head_valid !== w.hv)
					report_mismatch("head_valid", 32'(head_valid), 32'(w.hv));
				if (head_priority !== w.hp)
					report_mismatch("head_priority", 32'(head_priority), 32'(w.hp));
				if (head_data !== w.hd)
					report_mismatch("head_data", head_data, w.hd);
				if (occupancy !== w.occ)
					report_mismatch("occupancy", 32'(occupancy), 32'(w.occ));
				if (status !== w.st)
					report_mismatch("status", 32'(status), 32'(w.st));
			end
		end
	end

	initial begin : main_flow
		stretch_mode_e mode;
		bit            burst;
		stim_row_t     row;
		int            k;
		int            wait_cycles;

		// empty queue, then the extremes and ties, then fill past the top
		add_typed(ACT_POP, 16'h1234, 32'h0000_0000, 1'b0, 16'h0, 32'h0, 5'd0, ST_POP_EMPTY);
		add_typed(ACT_PEEK, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0, 32'h0, 5'd0, ST_DONE);
		add_typed(ACT_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0, 32'h0, 5'd0, ST_DONE);
		add_typed(ACT_PUSH, 16'h0000, 32'h0000_0000, 1'b1, 16'h0, 32'h0, 5'd1, ST_DONE);
		add_typed(ACT_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 5'd2,
			ST_DONE);
		// equal key queues up behind the older entry
		add_typed(ACT_PUSH, 16'hFFFF, 32'h0000_0001, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 5'd3,
			ST_DONE);
		add_row(ACT_PUSH, 16'h0000, 32'h0000_0002);
		add_row(ACT_PUSH, 16'h8000, 32'hA5A5_A5A5);
		add_row(ACT_PUSH, 16'h7FFF, 32'h5A5A_5A5A);
		add_row(ACT_PUSH, 16'h0001, 32'h1111_1111);
		add_row(ACT_PUSH, 16'hFFFE, 32'h2222_2222);
		add_row(ACT_PUSH, 16'h8000, 32'h3333_3333);
		add_row(ACT_PUSH, 16'h0000, 32'h4444_4444);
		add_row(ACT_PUSH, 16'h1234, 32'h5555_5555);
		add_row(ACT_PUSH, 16'h8000, 32'h6666_6666);
		add_row(ACT_PUSH, 16'h00FF, 32'h7777_7777);
		add_row(ACT_PUSH, 16'hFF00, 32'h8888_8888);
		add_row(ACT_PUSH, 16'h0001, 32'h9999_9999);
		add_row(ACT_PUSH, 16'h7FFF, 32'hCCCC_CCCC);
		add_typed(ACT_PUSH, 16'hFFFF, 32'hDEAD_BEEF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 5'd16,
			ST_PUSH_FULL);
		add_row(ACT_POP, 16'hFFFF, 32'hFFFF_FFFF);
		add_row(ACT_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
		add_row(ACT_POP, 16'h0000, 32'h0000_0000);
		add_row(ACT_PEEK, 16'h0000, 32'h0000_0000);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		for (k = 0; k < stim_table.size(); k++) begin
			issue(stim_table[k]);
			idle_cycles((k % 3 == 0) ? pick_gap() : 0);
		end

		// let the directed part drain before random traffic
		idle_cycles(1);
		while (pending_heads.size() != 0)
			@(posedge clk);

		// random stretches that sweep the queue between empty and full
		mode = MODE_MIX;
		burst = 1'b0;
		for (k = 0; k < 1300; k++) begin
			if (k % 50 == 0) begin
				if (shadow_count == 0)
					mode = MODE_FILL;
				else if (shadow_count == QDEPTH)
					mode = MODE_DRAIN;
				else
					mode = stretch_mode_e'($urandom_range(0, 2));
				burst = ($urandom_range(0, 9) < 3);
			end
			if (k == 650) begin
				// hold off until every pending result is back
				idle_cycles(1);
				while (pending_heads.size() != 0)
					@(posedge clk);
			end
			row = '0;
			row.act = pick_action(mode);
			row.prio = pick_priority();
			row.data = $urandom;
			issue(row);
			idle_cycles(burst ? 0 : pick_gap());
		end
		idle_cycles(1);

		// drain, then keep watching for any stray result
		wait_cycles = 0;
		while (pending_heads.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (4) @(posedge clk);
		if (pending_heads.size() != 0)
			report_mismatch("results never arrived", 32'(pending_heads.size()), 32'h0);

		$display("Checked %0d results: %0d pushes (%0d dropped full), %0d pops (%0d on empty),",
			results_seen, n_push, n_full, n_pop, n_empty);
		$display("%0d peeks, peak occupancy %0d, %0d mismatches", n_peek, peak_occ, errors);
		if (errors == 0)
			$display("** stable_max_priority_queue: PASSED **");
		else
			$display("** stable_max_priority_queue: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timeout with %0d results still pending", pending_heads.size());
		$display("** stable_max_priority_queue: FAILED **");
		$finish;
	end

endmodule
